// ===== rtl/cccf_pkg.sv =====
// ----------------------------------------------------------------------------
// cccf_pkg
// Shared constants and the gain table function for the chunk crossfade block.
// ----------------------------------------------------------------------------
package cccf_pkg;

   typedef longint unsigned wide_type;

   localparam int DEF_MAX_FADE    = 1024;
   localparam int DEF_PHASE_BITS  = 10;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int CSR_W       = 11;
   localparam int CHUNK_LEN_W = 16;
   localparam int GAIN_W      = 17;
   localparam int GAIN_FRAC   = 15;

   // bit positions inside req_tuser
   localparam int USER_KIND  = 0;
   localparam int USER_FIRST = 1;
   localparam int USER_W     = 2;

   // k * pi/2 in Q30 before scaling by the phase resolution
   localparam wide_type HALF_PI_Q30 = 64'd1686629713;

   // quarter-wave sine gain, Q1.15, from an odd Taylor series up to x^13
   function automatic logic [GAIN_W-1:0] gain_value(input int unsigned k,
                                                    input int unsigned phase_bits);
      wide_type x;
      wide_type term;
      longint   sum;
      x    = (wide_type'(k) * HALF_PI_Q30) >> phase_bits;
      term = x;
      sum  = longint'(x);
      for (int j = 1; j <= 6; j++) begin
         term = (((term * x) >> 30) * x) >> 30;
         case (j)
            1: begin
               term = term / 6;
            end
            2: begin
               term = term / 20;
            end
            3: begin
               term = term / 42;
            end
            4: begin
               term = term / 72;
            end
            5: begin
               term = term / 110;
            end
            default: begin
               term = term / 156;
            end
         endcase
         if (j[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
         sum = 64'sd1 <<< 30;
      end
      return GAIN_W'((sum + 64'sd16384) >>> 15);
   endfunction

endpackage

// ===== rtl/cccf_ring_mem.sv =====
// ----------------------------------------------------------------------------
// cccf_ring_mem
// Holdback ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cccf_ring_mem import cccf_pkg::*; #(
   parameter  int MAX_FADE    = DEF_MAX_FADE,
   parameter  int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int IDX_W       = (MAX_FADE > 1) ? $clog2(MAX_FADE) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  logic [SAMPLE_BITS-1:0] wr_data,
   input  logic                   rd_en,
   input  logic [IDX_W-1:0]       rd_addr,
   output logic [SAMPLE_BITS-1:0] rd_data
);

   logic [SAMPLE_BITS-1:0] mem [MAX_FADE];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cccf_gain_rom.sv =====
// ----------------------------------------------------------------------------
// cccf_gain_rom
// Quarter-wave gain table with two registered read ports (sin and cos).
// ----------------------------------------------------------------------------
module cccf_gain_rom import cccf_pkg::*; #(
   parameter  int PHASE_BITS = DEF_PHASE_BITS,
   localparam int KW         = PHASE_BITS + 1,
   localparam int DEPTH      = (1 << PHASE_BITS) + 1
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [KW-1:0]     addr_sin,
   input  logic [KW-1:0]     addr_cos,
   output logic [GAIN_W-1:0] gain_sin,
   output logic [GAIN_W-1:0] gain_cos
);

   logic [GAIN_W-1:0] rom [DEPTH];
   logic [GAIN_W-1:0] gain_sin_ff;
   logic [GAIN_W-1:0] gain_cos_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_rom
      assign rom[g] = gain_value(g, PHASE_BITS);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         gain_sin_ff <= rom[addr_sin];
         gain_cos_ff <= rom[addr_cos];
      end
   end

   assign gain_sin = gain_sin_ff;
   assign gain_cos = gain_cos_ff;

endmodule

// ===== rtl/cccf_phase_div.sv =====
// ----------------------------------------------------------------------------
// cccf_phase_div
// Bit-serial divider giving the phase index pos * 2^PHASE_BITS / fade.
// ----------------------------------------------------------------------------
module cccf_phase_div import cccf_pkg::*; #(
   parameter  int MAX_FADE   = DEF_MAX_FADE,
   parameter  int PHASE_BITS = DEF_PHASE_BITS,
   localparam int CNT_W      = $clog2(MAX_FADE + 1),
   localparam int CW         = $clog2(PHASE_BITS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [CNT_W-1:0]      numer,
   input  logic [CNT_W-1:0]      denom,
   output logic                  busy,
   output logic [PHASE_BITS-1:0] quot
);

   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      den_ff, den_in;
   logic [PHASE_BITS-1:0] quot_ff, quot_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CNT_W:0]        rem2;
   logic                  take;

   // numer < denom, so exactly PHASE_BITS quotient bits come out
   always_comb begin
      rem2     = {rem_ff, 1'b0};
      take     = rem2 >= {1'b0, den_ff};
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      if (start) begin
         rem_in   = numer;
         den_in   = denom;
         quot_in  = '0;
         count_in = CW'(PHASE_BITS);
      end else if (count_ff != '0) begin
         rem_in   = take ? CNT_W'(rem2 - {1'b0, den_ff}) : CNT_W'(rem2);
         quot_in  = {quot_ff[PHASE_BITS-2:0], take};
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy = count_ff != '0;
   assign quot = quot_ff;

endmodule

// ===== rtl/cccf_blend.sv =====
// ----------------------------------------------------------------------------
// cccf_blend
// Equal-power mix held*cos + new*sin on one shared multiplier, with rounding
// and saturation.
// ----------------------------------------------------------------------------
module cccf_blend import cccf_pkg::*; #(
   parameter  int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1,
   localparam int SUM_W       = PROD_W + 1,
   localparam int RES_W       = SUM_W - GAIN_FRAC
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SAMPLE_BITS-1:0] held,
   input  logic signed [SAMPLE_BITS-1:0] incoming,
   input  logic        [GAIN_W-1:0]      gain_cos,
   input  logic        [GAIN_W-1:0]      gain_sin,
   output logic                          done,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (GAIN_FRAC - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [2:0]                    phase_ff, phase_in;
   logic                          done_ff, done_in;
   logic signed [PROD_W-1:0]      prod_a_ff, prod_b_ff, prod;
   logic signed [SAMPLE_BITS-1:0] result_ff, result_in;
   logic signed [SAMPLE_BITS-1:0] mul_x;
   logic signed [GAIN_W:0]        mul_g;
   logic signed [SUM_W-1:0]       sum;
   logic signed [RES_W-1:0]       scaled;
   logic [RES_W-SAMPLE_BITS:0]    upper;

   // first step multiplies the held tail, second the new sample
   always_comb begin
      mul_x = phase_ff[0] ? held : incoming;
      mul_g = phase_ff[0] ? $signed({1'b0, gain_cos}) : $signed({1'b0, gain_sin});
      prod  = mul_x * mul_g;
   end

   always_comb begin
      sum    = SUM_W'(prod_a_ff) + SUM_W'(prod_b_ff) + ROUND_BIAS;
      scaled = sum[SUM_W-1:GAIN_FRAC];
      upper  = scaled[RES_W-1:SAMPLE_BITS-1];
      if (&upper || ~|upper) begin
         result_in = scaled[SAMPLE_BITS-1:0];
      end else if (scaled[RES_W-1]) begin
         result_in = SAT_LO;
      end else begin
         result_in = SAT_HI;
      end
      phase_in = {phase_ff[1:0], start};
      done_in  = phase_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff[0]) begin
         prod_a_ff <= prod;
      end
      if (phase_ff[1]) begin
         prod_b_ff <= prod;
      end
      if (phase_ff[2]) begin
         result_ff <= result_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== rtl/chunk_concat_crossfade.sv =====
// ----------------------------------------------------------------------------
// chunk_concat_crossfade: one item at a time. Each item goes from IDLE to
// DECIDE; a push, or a drain of an empty ring, then returns to IDLE.
// Pass-through and drain go through EMIT, which puts the result in the output
// register; a blended sample goes through DIV (bit-serial phase divider), GAIN
// and BLEND (shared blend multiplier). A waiting result holds the item in place.
// Synchronous reset clears the control state; the ring is not cleared.
// ----------------------------------------------------------------------------
module chunk_concat_crossfade import cccf_pkg::*; #(
   parameter  int MAX_FADE    = DEF_MAX_FADE,
   parameter  int PHASE_BITS  = DEF_PHASE_BITS,
   parameter  int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int REQ_W       = ((CHUNK_LEN_W + SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_data,    // longest fade length
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // chunk_length, sample_in
   input  logic [USER_W-1:0] req_tuser,   // kind, chunk_first
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // sample_out
   output logic              rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_FADE + 1);
   localparam int IDX_W = (MAX_FADE > 1) ? $clog2(MAX_FADE) : 1;
   localparam int KW    = PHASE_BITS + 1;
   localparam int CMP_W = CHUNK_LEN_W + 1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECIDE = 6'b000010,
      ST_EMIT   = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_GAIN   = 6'b010000,
      ST_BLEND  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       ring_head_ff, ring_head_in;
   logic [CNT_W-1:0]       ring_fill_ff, ring_fill_in;
   logic [CNT_W-1:0]       fade_len_ff, fade_len_in;
   logic [CNT_W-1:0]       fade_pos_ff, fade_pos_in;
   logic [CSR_W-1:0]       xfade_ff;
   logic                   emit_direct_ff, emit_direct_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   // transfer payload, held for the whole item
   logic                   kind_ff;
   logic                   first_ff;
   logic [CHUNK_LEN_W-1:0] clen_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;

   logic [CNT_W-1:0]       cap, fade_new, fl_eff, pos_eff;
   logic [CMP_W-1:0]       cap_cmp, min_cmp;
   logic                   fade_active;
   logic [IDX_W-1:0]       slot, push_addr, head_next;

   logic                   mem_we, mem_re;
   logic [IDX_W-1:0]       mem_waddr, mem_raddr;
   logic [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;

   logic                   div_start, div_busy;
   logic [PHASE_BITS-1:0]  div_quot;
   logic                   rom_re;
   logic [KW-1:0]          addr_sin, addr_cos;
   logic [GAIN_W-1:0]      gain_sin, gain_cos;
   logic                   blend_start, blend_done;
   logic [SAMPLE_BITS-1:0] blend_result;

   function automatic logic [IDX_W-1:0] ring_wrap(input logic [CNT_W:0] v);
      if (v >= (CNT_W+1)'(MAX_FADE)) begin
         return IDX_W'(v - (CNT_W+1)'(MAX_FADE));
      end
      return IDX_W'(v);
   endfunction

   // ring length and the fade length chosen at a chunk start
   always_comb begin
      cap_cmp = (CMP_W'(xfade_ff) > CMP_W'(MAX_FADE)) ? CMP_W'(MAX_FADE)
                                                      : CMP_W'(xfade_ff);
      cap     = CNT_W'(cap_cmp);
      min_cmp = cap_cmp;
      if (CMP_W'(ring_fill_ff) < min_cmp) begin
         min_cmp = CMP_W'(ring_fill_ff);
      end
      if (CMP_W'(clen_ff) < min_cmp) begin
         min_cmp = CMP_W'(clen_ff);
      end
      fade_new    = CNT_W'(min_cmp);
      fl_eff      = first_ff ? fade_new : fade_len_ff;
      pos_eff     = first_ff ? '0 : fade_pos_ff;
      fade_active = !kind_ff && (pos_eff < fl_eff);
      slot        = ring_wrap((CNT_W+1)'(ring_head_ff)
                              + (CNT_W+1)'(ring_fill_ff - fl_eff + pos_eff));
      push_addr   = ring_wrap((CNT_W+1)'(ring_head_ff) + (CNT_W+1)'(ring_fill_ff));
      head_next   = ring_wrap((CNT_W+1)'(ring_head_ff) + (CNT_W+1)'(1));
   end

   always_comb begin
      state_in       = state_ff;
      ring_head_in   = ring_head_ff;
      ring_fill_in   = ring_fill_ff;
      fade_len_in    = fade_len_ff;
      fade_pos_in    = fade_pos_ff;
      emit_direct_in = emit_direct_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      mem_waddr      = push_addr;
      mem_wdata      = sample_ff;
      mem_re         = 1'b0;
      mem_raddr      = ring_head_ff;
      div_start      = 1'b0;
      rom_re         = 1'b0;
      blend_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (kind_ff) begin
               fade_len_in = '0;
               fade_pos_in = '0;
               if (ring_fill_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_re         = 1'b1;
                  emit_direct_in = 1'b0;
                  state_in       = ST_EMIT;
               end
            end else begin
               fade_len_in = fl_eff;
               fade_pos_in = pos_eff;
               if (fade_active) begin
                  mem_re    = 1'b1;
                  mem_raddr = slot;
                  slot_in   = slot;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else if (ring_fill_ff < cap) begin
                  mem_we       = 1'b1;
                  ring_fill_in = ring_fill_ff + CNT_W'(1);
                  state_in     = ST_IDLE;
               end else if (ring_fill_ff == '0) begin
                  emit_direct_in = 1'b1;
                  state_in       = ST_EMIT;
               end else begin
                  mem_re         = 1'b1;
                  emit_direct_in = 1'b0;
                  state_in       = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            // waits here while the previous result is still unclaimed
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = emit_direct_ff ? sample_ff : mem_rdata;
               rsp_last_in  = kind_ff && (ring_fill_ff == CNT_W'(1));
               if (kind_ff) begin
                  ring_head_in = head_next;
                  ring_fill_in = ring_fill_ff - CNT_W'(1);
               end else if (!emit_direct_ff) begin
                  mem_we       = 1'b1;
                  ring_head_in = head_next;
               end
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            rom_re      = 1'b1;
            blend_start = 1'b1;
            state_in    = ST_BLEND;
         end
         ST_BLEND: begin
            if (blend_done) begin
               mem_we      = 1'b1;
               mem_waddr   = slot_ff;
               mem_wdata   = blend_result;
               fade_pos_in = fade_pos_ff + CNT_W'(1);
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ring_head_ff   <= '0;
         ring_fill_ff   <= '0;
         fade_len_ff    <= '0;
         fade_pos_ff    <= '0;
         xfade_ff       <= '0;
         emit_direct_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ring_head_ff   <= ring_head_in;
         ring_fill_ff   <= ring_fill_in;
         fade_len_ff    <= fade_len_in;
         fade_pos_ff    <= fade_pos_in;
         emit_direct_ff <= emit_direct_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid) begin
            xfade_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (req_tvalid && req_tready) begin
         kind_ff   <= req_tuser[USER_KIND];
         first_ff  <= req_tuser[USER_FIRST];
         clen_ff   <= req_tdata[CHUNK_LEN_W-1:0];
         sample_ff <= req_tdata[CHUNK_LEN_W +: SAMPLE_BITS];
      end
   end

   cccf_ring_mem #(
      .MAX_FADE    (MAX_FADE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   cccf_phase_div #(
      .MAX_FADE   (MAX_FADE),
      .PHASE_BITS (PHASE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (pos_eff),
      .denom (fl_eff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   assign addr_sin = KW'(div_quot);
   assign addr_cos = (KW'(1) << PHASE_BITS) - KW'(div_quot);

   cccf_gain_rom #(
      .PHASE_BITS (PHASE_BITS)
   ) u_rom (
      .clock    (clock),
      .rd_en    (rom_re),
      .addr_sin (addr_sin),
      .addr_cos (addr_cos),
      .gain_sin (gain_sin),
      .gain_cos (gain_cos)
   );

   cccf_blend #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_blend (
      .clock    (clock),
      .reset    (reset),
      .start    (blend_start),
      .held     ($signed(mem_rdata)),
      .incoming ($signed(sample_ff)),
      .gain_cos (gain_cos),
      .gain_sin (gain_sin),
      .done     (blend_done),
      .result   (blend_result)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

   // the fade window always lies inside the held samples
   a_fade_in_fill: assert property (@(posedge clock) disable iff (reset)
      fade_len_ff <= ring_fill_ff)
      else $error("fade length exceeds ring fill");

   a_pos_in_fade: assert property (@(posedge clock) disable iff (reset)
      fade_pos_ff <= fade_len_ff)
      else $error("fade position beyond fade length");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_DECIDE || state_ff == ST_EMIT || state_ff == ST_BLEND))
      else $error("ring write outside an item");

   a_blend_state: assert property (@(posedge clock) disable iff (reset)
      blend_done |-> state_ff == ST_BLEND)
      else $error("blend finished with no blend pending");

endmodule

// ===== sim/tb_chunk_concat_crossfade.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chunk_concat_crossfade
// Streams audio chunks and drain requests through the crossfade joiner and
// checks every output sample and its last flag against a cycle-free model of
// the holdback ring, the fade bookkeeping and the equal-power blend.
// ----------------------------------------------------------------------------
module tb_chunk_concat_crossfade;
   import cccf_pkg::*;

   localparam int RING_DEPTH  = 1024;
   localparam int PHASE_W     = 10;
   localparam int SMP_W       = 16;
   localparam int REQ_W       = 32;
   localparam int RSP_W       = 16;
   localparam int SETTLE      = 40;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   localparam bit KIND_SAMPLE = 1'b0;
   localparam bit KIND_DRAIN  = 1'b1;

   typedef struct packed {
      logic [SMP_W-1:0] sample;
      logic             last;
   } out_sample_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_data;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;   // chunk_length, sample_in
   logic [USER_W-1:0] req_tuser;   // kind, chunk_first
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;   // sample_out
   logic              rsp_tlast;

   // model state
   logic [SMP_W-1:0] ring_m [RING_DEPTH];
   int unsigned      head_m;
   int unsigned      fill_m;
   int unsigned      fade_len_m;
   int unsigned      fade_pos_m;
   int unsigned      xfade_setting;
   int               gain_lut [RING_DEPTH+1];

   out_sample_type awaited_samples [$];
   out_sample_type got_sample;
   int             errors;
   int             sent_count;
   int             idle_cycles;
   int             sender_gap_pct;
   int             receiver_gap_pct;
   bit             hold_request;
   int             hold_left;

   chunk_concat_crossfade u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // quarter-wave sine gain in Q1.15 from the truncated odd series
   function automatic int quarter_sine_gain(input int unsigned k);
      longint unsigned x;
      longint unsigned t;
      longint          acc;
      x = k;
      x = (x * 64'd1686629713) >> PHASE_W;
      t = x;
      acc = longint'(x);
      for (int j = 1; j <= 6; j++) begin
         t = (((t * x) >> 30) * x) >> 30;
         t = t / longint'((2 * j) * (2 * j + 1));
         if (j % 2 == 1) begin
            acc = acc - longint'(t);
         end else begin
            acc = acc + longint'(t);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > (64'sd1 <<< 30)) begin
         acc = 64'sd1 <<< 30;
      end
      return int'((acc + 64'sd16384) >>> 15);
   endfunction

   function automatic logic [SMP_W-1:0] crossfade_mix(input logic signed [SMP_W-1:0] held,
                                                      input logic signed [SMP_W-1:0] fresh,
                                                      input int unsigned pos,
                                                      input int unsigned len);
      int unsigned k;
      longint      acc;
      k   = (pos << PHASE_W) / len;
      acc = longint'(held) * longint'(gain_lut[(1 << PHASE_W) - k])
            + longint'(fresh) * longint'(gain_lut[k]) + 64'sd16384;
      acc = acc >>> 15;
      if (acc > 32767) begin
         acc = 32767;
      end
      if (acc < -32768) begin
         acc = -32768;
      end
      return acc[SMP_W-1:0];
   endfunction

   task automatic predict_stream_output(input bit kind, input bit first,
                                        input logic [15:0] clen,
                                        input logic [SMP_W-1:0] smp);
      int unsigned    cap;
      int unsigned    f;
      int unsigned    slot;
      out_sample_type o;
      cap = (xfade_setting < RING_DEPTH) ? xfade_setting : RING_DEPTH;
      if (kind == KIND_DRAIN) begin
         fade_len_m = 0;
         fade_pos_m = 0;
         if (fill_m == 0) begin
            return;
         end
         o.sample = ring_m[head_m];
         head_m   = (head_m + 1) % RING_DEPTH;
         fill_m   = fill_m - 1;
         o.last   = (fill_m == 0);
         awaited_samples.insert(awaited_samples.size(), o);
         return;
      end
      if (first) begin
         f = cap;
         if (fill_m < f) begin
            f = fill_m;
         end
         if (clen < f) begin
            f = clen;
         end
         fade_len_m = f;
         fade_pos_m = 0;
      end
      if (fade_pos_m < fade_len_m) begin
         slot = (head_m + (fill_m - fade_len_m) + fade_pos_m) % RING_DEPTH;
         ring_m[slot] = crossfade_mix(ring_m[slot], smp, fade_pos_m, fade_len_m);
         fade_pos_m = fade_pos_m + 1;
         return;
      end
      if (fill_m < cap) begin
         ring_m[(head_m + fill_m) % RING_DEPTH] = smp;
         fill_m = fill_m + 1;
         return;
      end
      o.last = 1'b0;
      if (fill_m == 0) begin
         o.sample = smp;
         awaited_samples.insert(awaited_samples.size(), o);
         return;
      end
      o.sample = ring_m[head_m];
      awaited_samples.insert(awaited_samples.size(), o);
      ring_m[(head_m + fill_m) % RING_DEPTH] = smp;
      head_m = (head_m + 1) % RING_DEPTH;
   endtask

   task automatic send_item(input bit kind, input bit first, input logic [15:0] clen,
                            input logic [SMP_W-1:0] smp);
      logic [USER_W-1:0] u;
      u = '0;
      u[USER_KIND]  = kind;
      u[USER_FIRST] = first;
      @(negedge clock);
      if (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {smp, clen};
      req_tuser  <= u;
      do @(posedge clock); while (!req_tready);
      predict_stream_output(kind, first, clen, smp);
      sent_count++;
   endtask

   // waits until the block has nothing left in flight
   task automatic wait_block_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_crossfade(input int unsigned value);
      wait_block_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value[CSR_W-1:0];
      do @(posedge clock); while (!csr_ready);
      xfade_setting = value & 32'h7FF;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_all();
      while (fill_m > 0) begin
         send_item(KIND_DRAIN, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
      end
      // one more on the empty ring, which must give nothing
      send_item(KIND_DRAIN, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
   endtask

   function automatic logic [SMP_W-1:0] rand_sample();
      case ($urandom_range(15))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int unsigned pick_setting();
      int r;
      r = $urandom_range(99);
      if (r < 65) begin
         return $urandom_range(16);
      end else if (r < 78) begin
         return $urandom_range(17, 64);
      end else if (r < 90) begin
         case ($urandom_range(2))
            0: return 1023;
            1: return 1024;
            default: return 2047;
         endcase
      end
      return $urandom_range(2047);
   endfunction

   // zero setting: drain on empty ring and straight pass-through at the extremes
   task automatic test_plain_concat();
      write_crossfade(0);
      send_item(KIND_DRAIN, 1'b1, 16'hFFFF, 16'h7FFF);
      send_item(KIND_SAMPLE, 1'b1, 16'd0, 16'h7FFF);
      send_item(KIND_SAMPLE, 1'b0, 16'hFFFF, 16'h8000);
      send_item(KIND_SAMPLE, 1'b1, 16'hFFFF, 16'h0000);
   endtask

   // setting above the ring size, saturating fades, zero length, fade cancels
   task automatic test_fade_corners();
      write_crossfade(2047);
      for (int i = 0; i < 3; i++) begin
         send_item(KIND_SAMPLE, i == 0, 16'd3, 16'h7FFF);
      end
      for (int i = 0; i < 3; i++) begin
         send_item(KIND_SAMPLE, i == 0, 16'hFFFF, 16'h7FFF);
      end
      send_item(KIND_SAMPLE, 1'b1, 16'd0, 16'h8000);
      send_item(KIND_SAMPLE, 1'b1, 16'd2, 16'h8000);
      send_item(KIND_SAMPLE, 1'b0, 16'd0, 16'h8000);
      // drain in the middle of a fade
      send_item(KIND_SAMPLE, 1'b1, 16'd5, 16'h4000);
      send_item(KIND_DRAIN, 1'b0, 16'd0, 16'h0000);
      send_item(KIND_SAMPLE, 1'b0, 16'd5, 16'hC000);
      // new chunk while a fade is running
      send_item(KIND_SAMPLE, 1'b1, 16'd4, 16'h1234);
      send_item(KIND_SAMPLE, 1'b1, 16'd1, 16'hEDCB);
      send_item(KIND_SAMPLE, 1'b0, 16'd1, 16'h0001);
      drain_all();
      write_crossfade(1);
      send_item(KIND_SAMPLE, 1'b1, 16'd1, 16'h7FFF);
      send_item(KIND_SAMPLE, 1'b1, 16'd1, 16'h8000);
      send_item(KIND_SAMPLE, 1'b0, 16'd1, 16'h0100);
      drain_all();
   endtask

   // receiver stops for a long stretch while the sender keeps offering samples
   task automatic test_backpressure();
      write_crossfade(4);
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_item(KIND_SAMPLE, i == 0, 16'd40, rand_sample());
      end
      drain_all();
   endtask

   task automatic test_random_chunks(input int n_items, input int s_gap, input int r_gap);
      int          start;
      int          n;
      int          chunks_left;
      logic [15:0] clen;
      int          r;
      sender_gap_pct   = s_gap;
      receiver_gap_pct = r_gap;
      start       = sent_count;
      chunks_left = 0;
      while (sent_count - start < n_items) begin
         if (chunks_left == 0) begin
            if ($urandom_range(1) == 0) begin
               drain_all();
            end
            write_crossfade(pick_setting());
            chunks_left = $urandom_range(3, 12);
         end
         chunks_left--;
         n = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
         r = $urandom_range(99);
         if (r < 80) begin
            clen = 16'(n);
         end else if (r < 90) begin
            clen = 16'($urandom);
         end else begin
            clen = 16'($urandom_range(3));
         end
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 3) begin
               send_item(KIND_DRAIN, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
            end
            if ($urandom_range(99) < 2) begin
               send_item(KIND_SAMPLE, 1'b1, 16'($urandom_range(40)), rand_sample());
            end
            send_item(KIND_SAMPLE, i == 0, (i == 0) ? clen : 16'($urandom), rand_sample());
         end
         if ($urandom_range(99) < 15) begin
            n = $urandom_range(1, fill_m + 1);
            repeat (n) begin
               send_item(KIND_DRAIN, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
            end
         end
      end
      drain_all();
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_samples.size() == 0) begin
            $error("unexpected output sample %h last %b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            got_sample = awaited_samples.pop_front();
            if (rsp_tdata[SMP_W-1:0] !== got_sample.sample) begin
               $error("sample_out: expected %h, got %h", got_sample.sample,
                      rsp_tdata[SMP_W-1:0]);
               errors++;
            end
            if (rsp_tlast !== got_sample.last) begin
               $error("is_last: expected %b, got %b", got_sample.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // output side readiness, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_gap_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_chunk_concat_crossfade: done, errors");
            $finish;
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      csr_valid        <= 1'b0;
      csr_data         <= '0;
      req_tvalid       <= 1'b0;
      req_tdata        <= '0;
      req_tuser        <= '0;
      rsp_tready       <= 1'b0;
      idle_cycles      <= 0;
      hold_request     = 1'b0;
      hold_left        = 0;
      errors           = 0;
      sent_count       = 0;
      head_m           = 0;
      fill_m           = 0;
      fade_len_m       = 0;
      fade_pos_m       = 0;
      xfade_setting    = 0;
      sender_gap_pct   = 11;
      receiver_gap_pct = 66;
      for (int k = 0; k <= RING_DEPTH; k++) begin
         gain_lut[k] = quarter_sine_gain(k);
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_plain_concat();
      test_fade_corners();
      test_random_chunks(290, 11, 66);
      test_random_chunks(290, 66, 11);
      test_random_chunks(290, 0, 0);
      test_backpressure();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("tb_chunk_concat_crossfade: done, clean");
      end else begin
         $display("tb_chunk_concat_crossfade: done, errors");
      end
      $finish;
   end

endmodule
